>>> rtl/cce_pkg.sv
// ----------------------------------------------------------------------------
// cce_pkg
// Shared types, constants and the syndrome table function for the (16,8)
// cyclic encoder / single-error corrector.
// ----------------------------------------------------------------------------
package cce_pkg;

    localparam int WORD_W = 16;
    localparam int BYTE_W = 8;
    localparam int SYN_W  = 8;
    localparam int STAT_W = 2;

    // x^7..x^0 of the default generator, x^8 implicit
    localparam logic [SYN_W-1:0] GEN_RESET = 8'b1001_0011;

    typedef enum logic {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_CLEAN  = 2'd0,
        ST_FIXED  = 2'd1,
        ST_UNCORR = 2'd2
    } status_t;

    typedef logic [SYN_W-1:0] syn_t;

    // entry i holds x^i mod g
    typedef syn_t [WORD_W-1:0] syn_tab_t;

    // front -> back queue entry
    typedef struct packed {
        cmd_t               cmd;
        logic [WORD_W-1:0]  word;   // encode: byte already moved to upper half
        syn_t               syn;
    } cce_item_t;

    function automatic syn_tab_t syn_table(input syn_t gen);
        syn_tab_t tab;
        syn_t     s;
        s = syn_t'(1);
        for (int i = 0; i < WORD_W; i++) begin
            tab[i] = s;
            s = s[SYN_W-1] ? ((s << 1) ^ gen) : (s << 1);
        end
        return tab;
    endfunction

endpackage

>>> rtl/cce_req_if.sv
// ----------------------------------------------------------------------------
// cce_req_if
// Request channel: command and word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cce_req_if;
    import cce_pkg::*;

    logic              valid;
    logic              ready;
    cmd_t              command;
    logic [WORD_W-1:0] word;

    modport source (output valid, output command, output word, input ready);
    modport sink   (input valid, input command, input word, output ready);

endinterface

>>> rtl/cce_rsp_if.sv
// ----------------------------------------------------------------------------
// cce_rsp_if
// Response channel: codeword, data byte and status, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cce_rsp_if;
    import cce_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] codeword;
    logic [BYTE_W-1:0] data_byte;
    logic [STAT_W-1:0] status;

    modport source (output valid, output codeword, output data_byte, output status,
                    input ready);
    modport sink   (input valid, input codeword, input data_byte, input status,
                    output ready);

endinterface

>>> rtl/cyclic_code_encode_correct.sv
// ----------------------------------------------------------------------------
// cyclic_code_encode_correct
// (16,8) systematic cyclic code: encode a byte, or decode a received word and
// correct a single bit error. Generator x^8 + cfg_data, set by cfg_wr_en.
//
// Channels: req carries a request (command, word) in; rsp carries the
// response (codeword, data_byte, status) out. Both use valid/ready; a
// request moves on an edge with valid and ready high.
// Throughput: one request per cycle, sustained, as long as rsp is taken.
// An accepted request is written into the queue, then into the output register.
// The front computes the remainder with an XOR tree over the syndrome
// table; a two-entry queue feeds the back, which runs the 16-way syndrome
// match and loads the output register.
// Stall: when rsp.ready is low the output holds; the queue fills up to its two
// entries, then req.ready drops until rsp drains.
// Reset: queue and output empty, generator back to x^8+x^7+x^4+x+1. The
// syndrome table is rebuilt on each generator write; write only when idle.
// ----------------------------------------------------------------------------
module cyclic_code_encode_correct (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [cce_pkg::SYN_W-1:0] cfg_data,
    cce_req_if.sink                 req,
    cce_rsp_if.source               rsp
);
    import cce_pkg::*;

    // x^i mod g for i = 0..15; low half is constant, kept for uniform indexing
    syn_tab_t  syn_tab_reg;

    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_not_empty;
    cce_item_t q_in;
    cce_item_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            syn_tab_reg <= syn_table(GEN_RESET);
        end
        else if (cfg_wr_en)
        begin
            syn_tab_reg <= syn_table(cfg_data);
        end
    end

    // front: accept and compute remainder
    cce_front u_front (
        .req     (req),
        .syn_tab (syn_tab_reg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_in)
    );

    // decoupling queue
    cce_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // back: correction and output register
    cce_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .syn_tab     (syn_tab_reg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .rsp         (rsp)
    );

endmodule

>>> rtl/cce_front.sv
// ----------------------------------------------------------------------------
// cce_front
// Accepts requests, forms the word to divide and computes its remainder.
// ----------------------------------------------------------------------------
module cce_front (
    cce_req_if.sink              req,
    input  cce_pkg::syn_tab_t    syn_tab,
    input  logic                 q_full,
    output logic                 q_push,
    output cce_pkg::cce_item_t   q_data
);
    import cce_pkg::*;

    logic [WORD_W-1:0] word_eff;
    syn_t              syn;

    assign req.ready = !q_full;
    assign q_push    = req.valid && !q_full;

    // encode divides byte * x^8
    assign word_eff = (req.command == CMD_ENCODE) ?
                      {req.word[BYTE_W-1:0], {(WORD_W-BYTE_W){1'b0}}} : req.word;

    // remainder is linear: XOR of x^i mod g over set bits
    always_comb
    begin
        syn = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (word_eff[i])
            begin
                syn = syn ^ syn_tab[i];
            end
        end
    end

    assign q_data.cmd  = req.command;
    assign q_data.word = word_eff;
    assign q_data.syn  = syn;

endmodule

>>> rtl/cce_queue.sv
// ----------------------------------------------------------------------------
// cce_queue
// Two-entry FIFO between front and back.
// ----------------------------------------------------------------------------
module cce_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  cce_pkg::cce_item_t   push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output cce_pkg::cce_item_t   head
);
    import cce_pkg::*;

    cce_item_t  mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/cce_back.sv
// ----------------------------------------------------------------------------
// cce_back
// Finishes one queued item: builds codeword or matches the syndrome against
// single-bit error syndromes, flips the lowest match, registers the response.
// ----------------------------------------------------------------------------
module cce_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cce_pkg::syn_tab_t    syn_tab,
    input  logic                 q_not_empty,
    input  cce_pkg::cce_item_t   q_head,
    output logic                 q_pop,
    cce_rsp_if.source            rsp
);
    import cce_pkg::*;

    logic              valid_reg, valid_next;
    logic [WORD_W-1:0] cw_reg, cw_next;
    status_t           status_reg, status_next;
    logic              found;
    logic [WORD_W-1:0] err_mask;

    assign q_pop = q_not_empty && (!valid_reg || rsp.ready);

    // lowest matching error position
    always_comb
    begin
        found    = 1'b0;
        err_mask = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (!found && (syn_tab[i] == q_head.syn))
            begin
                found       = 1'b1;
                err_mask[i] = 1'b1;
            end
        end
    end

    always_comb
    begin
        valid_next  = valid_reg;
        cw_next     = cw_reg;
        status_next = status_reg;
        if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
        if (q_pop)
        begin
            valid_next = 1'b1;
            case (q_head.cmd)
                CMD_ENCODE:
                begin
                    cw_next     = {q_head.word[WORD_W-1:SYN_W], q_head.syn};
                    status_next = ST_CLEAN;
                end
                CMD_DECODE:
                begin
                    if (q_head.syn == '0)
                    begin
                        cw_next     = q_head.word;
                        status_next = ST_CLEAN;
                    end
                    else if (found)
                    begin
                        cw_next     = q_head.word ^ err_mask;
                        status_next = ST_FIXED;
                    end
                    else
                    begin
                        cw_next     = q_head.word;
                        status_next = ST_UNCORR;
                    end
                end
                default:
                begin
                    cw_next     = q_head.word;
                    status_next = ST_UNCORR;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cw_reg     <= cw_next;
        status_reg <= status_next;
    end

    assign rsp.valid     = valid_reg;
    assign rsp.codeword  = cw_reg;
    assign rsp.data_byte = cw_reg[WORD_W-1:WORD_W-BYTE_W];
    assign rsp.status    = status_reg;

endmodule
